>>> rtl/cmh_pkg.sv
package cmh_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int TICK_WIDTH_DEF  = 24;
  localparam int HALF_W          = 32;
  localparam int ACT_W           = 17;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  localparam logic [ACT_W-1:0] Q_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLIP     = 3'd0,
    CFG_RESID    = 3'd1,
    CFG_FORCE    = 3'd2,
    CFG_FRIC     = 3'd3,
    CFG_TORQ     = 3'd4,
    CFG_DWELL    = 3'd5,
    CFG_GAIN     = 3'd6,
    CFG_ACT_STEP = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_FIXED    = 2'd0,
    MODE_ROLLING  = 2'd1,
    MODE_SLIDING  = 2'd2,
    MODE_DETACHED = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_FIXED    = 4'b0001,
    ST_ROLLING  = 4'b0010,
    ST_SLIDING  = 4'b0100,
    ST_DETACHED = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_FLAG = 2'd1,
    CAUSE_NEG  = 2'd2
  } cause_t;

  typedef struct packed {
    logic signed [HALF_W-1:0] slip_enter;
    logic signed [HALF_W-1:0] slip_exit;
    logic signed [HALF_W-1:0] resid_enter;
    logic signed [HALF_W-1:0] resid_exit;
    logic signed [HALF_W-1:0] force_enter;
    logic signed [HALF_W-1:0] force_exit;
    logic signed [HALF_W-1:0] fric_enter;
    logic signed [HALF_W-1:0] fric_exit;
    logic signed [HALF_W-1:0] torq_enter;
    logic signed [HALF_W-1:0] torq_exit;
    logic [ACT_W-1:0]         filter_gain;
    logic [ACT_W-1:0]         act_step;
  } cfg_t;

  function automatic state_t mode_to_state(input logic [1:0] m);
    state_t s;
    case (m)
      MODE_FIXED:   s = ST_FIXED;
      MODE_ROLLING: s = ST_ROLLING;
      MODE_SLIDING: s = ST_SLIDING;
      default:      s = ST_DETACHED;
    endcase
    return s;
  endfunction

  function automatic mode_t state_to_mode(input state_t s);
    mode_t m;
    case (s)
      ST_FIXED:   m = MODE_FIXED;
      ST_ROLLING: m = MODE_ROLLING;
      ST_SLIDING: m = MODE_SLIDING;
      default:    m = MODE_DETACHED;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/cmh_if.sv
interface cmh_in_if #(
  parameter int VW = cmh_pkg::VALUE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 meas_valid;
  logic signed [VW-1:0] slip_speed;
  logic signed [VW-1:0] rolling_residual;
  logic signed [VW-1:0] normal_force;
  logic signed [VW-1:0] friction_margin;
  logic signed [VW-1:0] torque_margin;
  logic [1:0]           wanted_mode;

  modport source (
    output valid, meas_valid, slip_speed, rolling_residual, normal_force,
           friction_margin, torque_margin, wanted_mode,
    input  ready
  );
  modport sink (
    input  valid, meas_valid, slip_speed, rolling_residual, normal_force,
           friction_margin, torque_margin, wanted_mode,
    output ready
  );
endinterface

interface cmh_out_if #(
  parameter int VW = cmh_pkg::VALUE_WIDTH_DEF,
  parameter int TW = cmh_pkg::TICK_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     estimated_mode;
  logic [cmh_pkg::ACT_W-1:0]      activation_level;
  logic signed [VW-1:0]           filtered_slip;
  logic                           measurement_ok;
  logic [1:0]                     invalid_cause;
  logic [TW-1:0]                  dwell_count;

  modport source (
    output valid, estimated_mode, activation_level, filtered_slip, measurement_ok,
           invalid_cause, dwell_count,
    input  ready
  );
  modport sink (
    input  valid, estimated_mode, activation_level, filtered_slip, measurement_ok,
           invalid_cause, dwell_count,
    output ready
  );
endinterface

>>> rtl/cmh_cfg.sv
module cmh_cfg #(
  parameter int TICK_WIDTH = cmh_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cmh_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cmh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cmh_pkg::cfg_t                  cfg,
  output logic [TICK_WIDTH-1:0]          min_dwell
);

  cmh_pkg::cfg_t         cfg_r, cfg_nxt;
  logic [TICK_WIDTH-1:0] dwell_r, dwell_nxt;

  always_comb begin
    cfg_nxt   = cfg_r;
    dwell_nxt = dwell_r;
    if (cfg_we) begin
      case (cmh_pkg::cfg_idx_t'(cfg_idx))
        cmh_pkg::CFG_SLIP: begin
          cfg_nxt.slip_enter = cfg_wdata[63:32];
          cfg_nxt.slip_exit  = cfg_wdata[31:0];
        end
        cmh_pkg::CFG_RESID: begin
          cfg_nxt.resid_enter = cfg_wdata[63:32];
          cfg_nxt.resid_exit  = cfg_wdata[31:0];
        end
        cmh_pkg::CFG_FORCE: begin
          cfg_nxt.force_enter = cfg_wdata[63:32];
          cfg_nxt.force_exit  = cfg_wdata[31:0];
        end
        cmh_pkg::CFG_FRIC: begin
          cfg_nxt.fric_enter = cfg_wdata[63:32];
          cfg_nxt.fric_exit  = cfg_wdata[31:0];
        end
        cmh_pkg::CFG_TORQ: begin
          cfg_nxt.torq_enter = cfg_wdata[63:32];
          cfg_nxt.torq_exit  = cfg_wdata[31:0];
        end
        cmh_pkg::CFG_DWELL:    dwell_nxt           = cfg_wdata[TICK_WIDTH-1:0];
        cmh_pkg::CFG_GAIN:     cfg_nxt.filter_gain = cfg_wdata[cmh_pkg::ACT_W-1:0];
        cmh_pkg::CFG_ACT_STEP: cfg_nxt.act_step    = cfg_wdata[cmh_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '{filter_gain: cmh_pkg::Q_ONE, act_step: cmh_pkg::Q_ONE, default: '0};
      dwell_r <= '0;
    end else begin
      cfg_r   <= cfg_nxt;
      dwell_r <= dwell_nxt;
    end
  end

  assign cfg       = cfg_r;
  assign min_dwell = dwell_r;

endmodule

>>> rtl/cmh_core.sv
module cmh_core #(
  parameter int VALUE_WIDTH = cmh_pkg::VALUE_WIDTH_DEF,
  parameter int TICK_WIDTH  = cmh_pkg::TICK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  cmh_pkg::cfg_t                 cfg,
  input  logic [TICK_WIDTH-1:0]         min_dwell,
  input  logic                          meas_valid,
  input  logic signed [VALUE_WIDTH-1:0] slip_speed,
  input  logic signed [VALUE_WIDTH-1:0] rolling_residual,
  input  logic signed [VALUE_WIDTH-1:0] normal_force,
  input  logic signed [VALUE_WIDTH-1:0] friction_margin,
  input  logic signed [VALUE_WIDTH-1:0] torque_margin,
  input  logic [1:0]                    wanted_mode,
  output logic [1:0]                    res_mode,
  output logic [cmh_pkg::ACT_W-1:0]     res_act,
  output logic signed [VALUE_WIDTH-1:0] res_filt,
  output logic                          res_ok,
  output logic [1:0]                    res_cause,
  output logic [TICK_WIDTH-1:0]         res_dwell
);

  localparam int VW  = VALUE_WIDTH;
  localparam int AW  = cmh_pkg::ACT_W;
  localparam int CW  = ((VW > cmh_pkg::HALF_W) ? VW : cmh_pkg::HALF_W) + 2;
  localparam int PW  = VW + AW + 2;

  cmh_pkg::state_t       cur_r, cur_nxt, pend_r, pend_nxt, req_st, desired;
  logic [TICK_WIDTH-1:0] pt_r, pt_nxt, dwell_r, dwell_nxt;
  logic [TICK_WIDTH-1:0] dwell_inc, pt_base, pt_new;
  logic signed [VW-1:0]  filt_r, filt_nxt, filt_upd;
  logic [AW-1:0]         act_r, act_nxt;

  logic                  ok;
  cmh_pkg::cause_t       cause;
  logic [AW-1:0]         gain_eff, step_eff, target;
  logic signed [VW:0]    diff;
  logic [PW-1:0]         prod;
  logic signed [CW-1:0]  filt_c, resid_c, mag_c, force_c, fric_c, torq_c;
  logic                  force_low, slipping, recovered, hard_det;
  logic signed [AW+1:0]  delta, step_s, act_s;

  assign ok = meas_valid && !slip_speed[VW-1];

  always_comb begin
    if (!meas_valid)    cause = cmh_pkg::CAUSE_FLAG;
    else if (!ok)       cause = cmh_pkg::CAUSE_NEG;
    else                cause = cmh_pkg::CAUSE_NONE;
  end

  assign gain_eff = (cfg.filter_gain > cmh_pkg::Q_ONE) ? cmh_pkg::Q_ONE : cfg.filter_gain;
  assign step_eff = (cfg.act_step > cmh_pkg::Q_ONE) ? cmh_pkg::Q_ONE : cfg.act_step;

  assign diff     = {slip_speed[VW-1], slip_speed} - {filt_r[VW-1], filt_r};
  assign prod     = diff * $signed({1'b0, gain_eff});
  assign filt_upd = filt_r + $signed(prod[VW+15:16]);

  assign filt_c  = CW'(filt_upd);
  assign resid_c = CW'(rolling_residual);
  assign mag_c   = resid_c[CW-1] ? -resid_c : resid_c;
  assign force_c = CW'(normal_force);
  assign fric_c  = CW'(friction_margin);
  assign torq_c  = CW'(torque_margin);

  assign force_low = force_c < CW'(cfg.force_exit);
  assign slipping  = (filt_c > CW'(cfg.slip_enter)) || (mag_c > CW'(cfg.resid_enter)) ||
                     (fric_c < CW'(cfg.fric_exit)) || (torq_c < CW'(cfg.torq_exit));
  assign recovered = (filt_c < CW'(cfg.slip_exit)) && (mag_c < CW'(cfg.resid_exit)) &&
                     (force_c > CW'(cfg.force_enter)) && (fric_c > CW'(cfg.fric_enter)) &&
                     (torq_c > CW'(cfg.torq_enter));

  assign req_st   = cmh_pkg::mode_to_state(wanted_mode);
  assign hard_det = (req_st == cmh_pkg::ST_DETACHED) || force_low;

  always_comb begin
    if (hard_det)                                  desired = cmh_pkg::ST_DETACHED;
    else if (req_st == cmh_pkg::ST_SLIDING)        desired = cmh_pkg::ST_SLIDING;
    else if (cur_r == cmh_pkg::ST_DETACHED)        desired = recovered ? req_st
                                                                       : cmh_pkg::ST_DETACHED;
    else if (cur_r == cmh_pkg::ST_SLIDING && !recovered) desired = cmh_pkg::ST_SLIDING;
    else if (slipping)                             desired = cmh_pkg::ST_SLIDING;
    else                                           desired = req_st;
  end

  assign dwell_inc = (&dwell_r) ? dwell_r : dwell_r + 1'b1;
  assign pt_base   = (pend_r != desired) ? '0 : pt_r;
  assign pt_new    = (&pt_base) ? pt_base : pt_base + 1'b1;

  always_comb begin
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    pt_nxt    = pt_r;
    dwell_nxt = dwell_r;
    filt_nxt  = filt_r;
    if (step_en) begin
      dwell_nxt = dwell_inc;
      if (!ok) begin
        filt_nxt  = '0;
        cur_nxt   = cmh_pkg::ST_DETACHED;
        pend_nxt  = cmh_pkg::ST_DETACHED;
        pt_nxt    = '0;
        dwell_nxt = '0;
      end else begin
        filt_nxt = filt_upd;
        if (desired == cur_r) begin
          pend_nxt = desired;
          pt_nxt   = '0;
        end else if (hard_det || pt_new >= min_dwell) begin
          cur_nxt   = desired;
          pend_nxt  = desired;
          pt_nxt    = '0;
          dwell_nxt = '0;
        end else begin
          pend_nxt = desired;
          pt_nxt   = pt_new;
        end
      end
    end
  end

  assign target = (cur_nxt == cmh_pkg::ST_DETACHED) ? '0 : cmh_pkg::Q_ONE;
  assign delta  = $signed({2'b00, target}) - $signed({2'b00, act_r});
  assign step_s = $signed({2'b00, step_eff});

  always_comb begin
    if (delta > step_s)       act_s = $signed({2'b00, act_r}) + step_s;
    else if (delta < -step_s) act_s = $signed({2'b00, act_r}) - step_s;
    else                      act_s = $signed({2'b00, target});
    act_nxt = step_en ? act_s[AW-1:0] : act_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= cmh_pkg::ST_DETACHED;
      pend_r  <= cmh_pkg::ST_DETACHED;
      pt_r    <= '0;
      dwell_r <= '0;
      filt_r  <= '0;
      act_r   <= '0;
    end else begin
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      pt_r    <= pt_nxt;
      dwell_r <= dwell_nxt;
      filt_r  <= filt_nxt;
      act_r   <= act_nxt;
    end
  end

  assign res_mode  = cmh_pkg::state_to_mode(cur_nxt);
  assign res_act   = act_nxt;
  assign res_filt  = filt_nxt;
  assign res_ok    = ok;
  assign res_cause = cause;
  assign res_dwell = dwell_nxt;

  a_reject_detaches: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !ok |=> cur_r == cmh_pkg::ST_DETACHED && filt_r == '0 && dwell_r == '0)
    else $error("rejected beat did not force detached");

  a_act_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= cmh_pkg::Q_ONE)
    else $error("activation above one");

  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(cur_r) && $onehot(pend_r))
    else $error("mode state not one-hot");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(cur_r) && $stable(filt_r) && $stable(act_r) && $stable(dwell_r))
    else $error("state moved without a beat");

endmodule

>>> rtl/contact_mode_hysteresis_fsm_unit.sv
// Contact mode estimator with enter/exit hysteresis, dwell and activation ramp.
//
// in_bus carries one control tick per beat (valid/ready); out_bus returns one
// result beat for every input beat, in order. Configuration registers are
// written through cfg_wdata, cfg_idx and cfg_we, one register per cycle; the user
// must write only while the block is idle; the block does not enforce this.
//
// An accepted beat is held in the input register, and its result is loaded
// into the result register once it is free (input register, then result
// register). Throughput: one beat per cycle unless the receiver stalls; the
// per-beat work is a single filter multiply feeding the threshold compares
// and the mode update, all between the input register and the result register.
//
// Reset (rst_n low, synchronous): mode detached, counters, filter and
// activation cleared, thresholds 0, dwell 0, filter gain and activation step 1.
//
// When the receiver stalls, the result register holds its beat and the
// input register takes one more beat; after that in_bus.ready drops.
module contact_mode_hysteresis_fsm_unit #(
  parameter int VALUE_WIDTH = cmh_pkg::VALUE_WIDTH_DEF,
  parameter int TICK_WIDTH  = cmh_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cmh_in_if.sink                         in_bus,
  cmh_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [cmh_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cmh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = cmh_pkg::ACT_W;

  cmh_pkg::cfg_t         cfg;
  logic [TICK_WIDTH-1:0] min_dwell;

  logic                  in_vld_r, in_vld_nxt;
  logic                  mv_r;
  logic signed [VW-1:0]  slip_r, resid_r, force_r, fric_r, torq_r;
  logic [1:0]            want_r;
  logic                  in_acc, adv;

  logic                  out_vld_r, out_vld_nxt;
  logic [1:0]            mode_r;
  logic [AW-1:0]         act_r;
  logic signed [VW-1:0]  filt_r;
  logic                  ok_r;
  logic [1:0]            cause_r;
  logic [TICK_WIDTH-1:0] dwell_r;

  logic [1:0]            res_mode;
  logic [AW-1:0]         res_act;
  logic signed [VW-1:0]  res_filt;
  logic                  res_ok;
  logic [1:0]            res_cause;
  logic [TICK_WIDTH-1:0] res_dwell;

  assign adv          = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || adv;
  assign in_acc       = in_bus.valid && in_bus.ready;

  assign in_vld_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_bus.ready ? 1'b0 : out_vld_r);

  cmh_cfg #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .min_dwell (min_dwell)
  );

  cmh_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (adv),
    .cfg              (cfg),
    .min_dwell        (min_dwell),
    .meas_valid       (mv_r),
    .slip_speed       (slip_r),
    .rolling_residual (resid_r),
    .normal_force     (force_r),
    .friction_margin  (fric_r),
    .torque_margin    (torq_r),
    .wanted_mode      (want_r),
    .res_mode         (res_mode),
    .res_act          (res_act),
    .res_filt         (res_filt),
    .res_ok           (res_ok),
    .res_cause        (res_cause),
    .res_dwell        (res_dwell)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mv_r    <= in_bus.meas_valid;
      slip_r  <= in_bus.slip_speed;
      resid_r <= in_bus.rolling_residual;
      force_r <= in_bus.normal_force;
      fric_r  <= in_bus.friction_margin;
      torq_r  <= in_bus.torque_margin;
      want_r  <= in_bus.wanted_mode;
    end
    if (adv) begin
      mode_r  <= res_mode;
      act_r   <= res_act;
      filt_r  <= res_filt;
      ok_r    <= res_ok;
      cause_r <= res_cause;
      dwell_r <= res_dwell;
    end
  end

  assign out_bus.valid            = out_vld_r;
  assign out_bus.estimated_mode   = mode_r;
  assign out_bus.activation_level = act_r;
  assign out_bus.filtered_slip    = filt_r;
  assign out_bus.measurement_ok   = ok_r;
  assign out_bus.invalid_cause    = cause_r;
  assign out_bus.dwell_count      = dwell_r;

endmodule

>>> dv/contact_mode_hysteresis_fsm_unit_tb.sv
`timescale 1ns / 100ps

module contact_mode_hysteresis_fsm_unit_tb;

  localparam int VW         = cmh_pkg::VALUE_WIDTH_DEF;
  localparam int TW         = cmh_pkg::TICK_WIDTH_DEF;
  localparam int AW         = cmh_pkg::ACT_W;
  localparam int DW         = cmh_pkg::CFG_DATA_W;
  localparam int HW         = cmh_pkg::HALF_W;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 150;
  localparam int PHASES     = 11;
  localparam int PHASE_LEN  = 80;

  typedef struct packed {
    logic                 meas_valid;
    logic signed [VW-1:0] slip_speed;
    logic signed [VW-1:0] rolling_residual;
    logic signed [VW-1:0] normal_force;
    logic signed [VW-1:0] friction_margin;
    logic signed [VW-1:0] torque_margin;
    logic [1:0]           wanted_mode;
  } tick_in_t;

  typedef struct packed {
    logic [1:0]           estimated_mode;
    logic [AW-1:0]        activation_level;
    logic signed [VW-1:0] filtered_slip;
    logic                 measurement_ok;
    logic [1:0]           invalid_cause;
    logic [TW-1:0]        dwell_count;
  } tick_out_t;

  class contact_estimate_board;
    logic [DW-1:0]         limits [5];
    logic [TW-1:0]         dwell_need;
    logic [AW-1:0]         gain;
    logic [AW-1:0]         ramp;
    cmh_pkg::mode_t        mode_now;
    cmh_pkg::mode_t        mode_next;
    logic [TW-1:0]         next_ticks;
    logic [TW-1:0]         since_commit;
    logic signed [VW-1:0]  filt;
    logic [AW-1:0]         act;
    tick_out_t             pending_estimates [$];
    int                    mismatches;
    int                    checked;
    int                    rejects;
    int                    commits;

    function new();
      foreach (limits[k]) limits[k] = '0;
      dwell_need   = '0;
      gain         = cmh_pkg::Q_ONE;
      ramp         = cmh_pkg::Q_ONE;
      mode_now     = cmh_pkg::MODE_DETACHED;
      mode_next    = cmh_pkg::MODE_DETACHED;
      next_ticks   = '0;
      since_commit = '0;
      filt         = '0;
      act          = '0;
      mismatches   = 0;
      checked      = 0;
      rejects      = 0;
      commits      = 0;
    endfunction

    function void set_reg(cmh_pkg::cfg_idx_t k, logic [DW-1:0] v);
      case (k)
        cmh_pkg::CFG_DWELL:    dwell_need = v[TW-1:0];
        cmh_pkg::CFG_GAIN:     gain = v[AW-1:0];
        cmh_pkg::CFG_ACT_STEP: ramp = v[AW-1:0];
        default:               limits[k] = v;
      endcase
    endfunction

    function longint wide(logic [VW-1:0] v);
      return longint'($signed(v));
    endfunction

    function longint enter_of(cmh_pkg::cfg_idx_t k);
      return longint'($signed(limits[k][2*HW-1:HW]));
    endfunction

    function longint exit_of(cmh_pkg::cfg_idx_t k);
      return longint'($signed(limits[k][HW-1:0]));
    endfunction

    function logic [TW-1:0] bump(logic [TW-1:0] t);
      return (&t) ? t : t + 1'b1;
    endfunction

    function void settle(cmh_pkg::mode_t m);
      mode_now     = m;
      mode_next    = m;
      since_commit = '0;
      next_ticks   = '0;
      commits++;
    endfunction

    function void take_tick(tick_in_t t);
      tick_out_t      r;
      longint         g, filt_v, mag, target, step, delta;
      logic           ok, low_force, slipping, recovered;
      cmh_pkg::mode_t want, desired;
      ok = t.meas_valid && !t.slip_speed[VW-1];
      since_commit = bump(since_commit);
      r.invalid_cause = cmh_pkg::CAUSE_NONE;
      if (!ok) begin
        r.invalid_cause = t.meas_valid ? cmh_pkg::CAUSE_NEG : cmh_pkg::CAUSE_FLAG;
        rejects++;
        filt = '0;
        settle(cmh_pkg::MODE_DETACHED);
      end else begin
        g = (gain > cmh_pkg::Q_ONE) ? longint'(cmh_pkg::Q_ONE) : longint'(gain);
        filt_v = wide(filt);
        filt_v = filt_v + ((g * (wide(t.slip_speed) - filt_v)) >>> 16);
        filt = filt_v[VW-1:0];
        mag = wide(t.rolling_residual);
        if (mag < 0) mag = -mag;
        want = cmh_pkg::mode_t'(t.wanted_mode);
        low_force = wide(t.normal_force) < exit_of(cmh_pkg::CFG_FORCE);
        slipping = filt_v > enter_of(cmh_pkg::CFG_SLIP) ||
                   mag > enter_of(cmh_pkg::CFG_RESID) ||
                   wide(t.friction_margin) < exit_of(cmh_pkg::CFG_FRIC) ||
                   wide(t.torque_margin) < exit_of(cmh_pkg::CFG_TORQ);
        recovered = filt_v < exit_of(cmh_pkg::CFG_SLIP) &&
                    mag < exit_of(cmh_pkg::CFG_RESID) &&
                    wide(t.normal_force) > enter_of(cmh_pkg::CFG_FORCE) &&
                    wide(t.friction_margin) > enter_of(cmh_pkg::CFG_FRIC) &&
                    wide(t.torque_margin) > enter_of(cmh_pkg::CFG_TORQ);
        if (want == cmh_pkg::MODE_DETACHED || low_force) desired = cmh_pkg::MODE_DETACHED;
        else if (want == cmh_pkg::MODE_SLIDING) desired = cmh_pkg::MODE_SLIDING;
        else if (mode_now == cmh_pkg::MODE_DETACHED)
          desired = recovered ? want : cmh_pkg::MODE_DETACHED;
        else if (mode_now == cmh_pkg::MODE_SLIDING && !recovered)
          desired = cmh_pkg::MODE_SLIDING;
        else if (slipping) desired = cmh_pkg::MODE_SLIDING;
        else desired = want;
        if (desired == mode_now) begin
          mode_next  = desired;
          next_ticks = '0;
        end else if (desired == cmh_pkg::MODE_DETACHED &&
                     (want == cmh_pkg::MODE_DETACHED || low_force)) begin
          settle(desired);
        end else begin
          if (mode_next != desired) begin
            mode_next  = desired;
            next_ticks = '0;
          end
          next_ticks = bump(next_ticks);
          if (next_ticks >= dwell_need) settle(desired);
        end
      end
      target = (mode_now == cmh_pkg::MODE_DETACHED) ? 0 : longint'(cmh_pkg::Q_ONE);
      step = (ramp > cmh_pkg::Q_ONE) ? longint'(cmh_pkg::Q_ONE) : longint'(ramp);
      delta = target - longint'(act);
      if (delta > step) delta = step;
      if (delta < -step) delta = -step;
      act = AW'(longint'(act) + delta);
      r.estimated_mode   = mode_now;
      r.activation_level = act;
      r.filtered_slip    = filt;
      r.measurement_ok   = ok;
      r.dwell_count      = since_commit;
      pending_estimates.push_back(r);
    endfunction

    function void check_estimate(tick_out_t got);
      tick_out_t want_r;
      if (pending_estimates.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
        return;
      end
      want_r = pending_estimates.pop_front();
      checked++;
      if (got.estimated_mode !== want_r.estimated_mode) begin
        $error("estimated_mode: expected %0d, got %0d",
               want_r.estimated_mode, got.estimated_mode);
        mismatches++;
      end
      if (got.activation_level !== want_r.activation_level) begin
        $error("activation_level: expected %0d, got %0d",
               want_r.activation_level, got.activation_level);
        mismatches++;
      end
      if (got.filtered_slip !== want_r.filtered_slip) begin
        $error("filtered_slip: expected %0d, got %0d",
               want_r.filtered_slip, got.filtered_slip);
        mismatches++;
      end
      if (got.measurement_ok !== want_r.measurement_ok) begin
        $error("measurement_ok: expected %0d, got %0d",
               want_r.measurement_ok, got.measurement_ok);
        mismatches++;
      end
      if (got.invalid_cause !== want_r.invalid_cause) begin
        $error("invalid_cause: expected %0d, got %0d",
               want_r.invalid_cause, got.invalid_cause);
        mismatches++;
      end
      if (got.dwell_count !== want_r.dwell_count) begin
        $error("dwell_count: expected %0d, got %0d",
               want_r.dwell_count, got.dwell_count);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cmh_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [DW-1:0]                 cfg_wdata;

  cmh_in_if  in_bus ();
  cmh_out_if out_bus ();

  contact_mode_hysteresis_fsm_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  contact_estimate_board board = new();

  logic [DW-1:0]         img [8];
  int unsigned           sc_slip, sc_res, sc_force, sc_fric, sc_torq;
  cmh_pkg::mode_t        held_mode = cmh_pkg::MODE_FIXED;
  bit                    burst     = 1'b0;
  bit                    squeeze   = 1'b0;
  int                    settings  = 0;
  int                    idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic tick_in_t tick_of(bit mv, int s, int r, int f, int fr, int tq,
                                       cmh_pkg::mode_t m);
    tick_in_t t;
    t.meas_valid       = mv;
    t.slip_speed       = s;
    t.rolling_residual = r;
    t.normal_force     = f;
    t.friction_margin  = fr;
    t.torque_margin    = tq;
    t.wanted_mode      = m;
    return t;
  endfunction

  function automatic tick_in_t shaped_tick();
    tick_in_t    t;
    int unsigned r;
    if ($urandom_range(0, 99) < 12) begin
      t.meas_valid       = $urandom_range(0, 1);
      t.slip_speed       = $urandom;
      t.rolling_residual = $urandom;
      t.normal_force     = $urandom;
      t.friction_margin  = $urandom;
      t.torque_margin    = $urandom;
      t.wanted_mode      = $urandom_range(0, 3);
      return t;
    end
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, 9);
      held_mode = (r < 4) ? cmh_pkg::MODE_FIXED : (r < 8) ? cmh_pkg::MODE_ROLLING :
                  (r < 9) ? cmh_pkg::MODE_SLIDING : cmh_pkg::MODE_DETACHED;
    end
    t.meas_valid = ($urandom_range(0, 49) != 0);
    t.slip_speed = ($urandom_range(0, 39) == 0) ? -int'($urandom_range(1, sc_slip)) :
                                                   int'($urandom_range(0, 3 * sc_slip));
    r = $urandom_range(0, 2 * sc_res);
    t.rolling_residual = $urandom_range(0, 1) ? -int'(r) : int'(r);
    if ($urandom_range(0, 49) == 0) t.rolling_residual = 32'h8000_0000;
    t.normal_force = ($urandom_range(0, 19) == 0) ? $urandom_range(0, sc_force) :
                                                     $urandom_range(sc_force / 2, 3 * sc_force);
    t.friction_margin = ($urandom_range(0, 19) == 0) ? -int'($urandom_range(0, sc_fric)) :
                                                        int'($urandom_range(0, 3 * sc_fric));
    t.torque_margin = ($urandom_range(0, 19) == 0) ? -int'($urandom_range(0, sc_torq)) :
                                                      int'($urandom_range(0, 3 * sc_torq));
    t.wanted_mode = held_mode;
    return t;
  endfunction

  function automatic void fill_limits();
    img[cmh_pkg::CFG_SLIP]  = {32'(sc_slip), 32'(sc_slip / 2)};
    img[cmh_pkg::CFG_RESID] = {32'(sc_res), 32'(sc_res / 2)};
    img[cmh_pkg::CFG_FORCE] = {32'(sc_force), 32'(sc_force / 2)};
    img[cmh_pkg::CFG_FRIC]  = {32'(sc_fric), 32'(sc_fric / 2)};
    img[cmh_pkg::CFG_TORQ]  = {32'(sc_torq), 32'(sc_torq / 2)};
  endfunction

  task automatic program_regs();
    cmh_pkg::cfg_idx_t k;
    k = k.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_idx   <= k;
      cfg_wdata <= img[k];
      board.set_reg(k, img[k]);
      @(posedge clk);
      k = k.next();
    end while (k != k.first());
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_tick(input tick_in_t t);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.meas_valid       <= t.meas_valid;
    in_bus.slip_speed       <= t.slip_speed;
    in_bus.rolling_residual <= t.rolling_residual;
    in_bus.normal_force     <= t.normal_force;
    in_bus.friction_margin  <= t.friction_margin;
    in_bus.torque_margin    <= t.torque_margin;
    in_bus.wanted_mode      <= t.wanted_mode;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic settle_all();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_estimates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      board.take_tick(tick_in_t'{
        meas_valid:       in_bus.meas_valid,
        slip_speed:       in_bus.slip_speed,
        rolling_residual: in_bus.rolling_residual,
        normal_force:     in_bus.normal_force,
        friction_margin:  in_bus.friction_margin,
        torque_margin:    in_bus.torque_margin,
        wanted_mode:      in_bus.wanted_mode});
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      board.check_estimate(tick_out_t'{
        estimated_mode:   out_bus.estimated_mode,
        activation_level: out_bus.activation_level,
        filtered_slip:    out_bus.filtered_slip,
        measurement_ok:   out_bus.measurement_ok,
        invalid_cause:    out_bus.invalid_cause,
        dwell_count:      out_bus.dwell_count});
    end
  end

  // hold off the result side; a long hold on request backs up the input
  initial begin
    int gap;
    int run_len;
    forever begin
      if (squeeze) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        squeeze = 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) :
                                                 $urandom_range(1, 12);
        while (run_len > 0 && !squeeze) begin
          @(posedge clk);
          run_len--;
        end
        gap = squeeze ? 0 : pick_gap();
        while (gap > 0 && !squeeze) begin
          out_bus.ready <= 1'b0;
          @(posedge clk);
          gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= '0;
    cfg_wdata               <= '0;
    in_bus.valid            <= 1'b0;
    in_bus.meas_valid       <= 1'b0;
    in_bus.slip_speed       <= '0;
    in_bus.rolling_residual <= '0;
    in_bus.normal_force     <= '0;
    in_bus.friction_margin  <= '0;
    in_bus.torque_margin    <= '0;
    in_bus.wanted_mode      <= cmh_pkg::MODE_FIXED;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    sc_slip  = 32'h2_0000;
    sc_res   = 32'h8000;
    sc_force = 32'h8_0000;
    sc_fric  = 32'h4000;
    sc_torq  = 32'h4000;
    fill_limits();
    img[cmh_pkg::CFG_DWELL]    = 2;
    img[cmh_pkg::CFG_GAIN]     = 32'h8000;
    img[cmh_pkg::CFG_ACT_STEP] = 32'h8000;
    program_regs();

    send_tick(tick_of(1'b0, 'h8000_0000, 0, 0, 0, 0, cmh_pkg::MODE_FIXED));
    send_tick(tick_of(1'b1, -1, 'h1000, 'hA_0000, 'h6000, 'h6000, cmh_pkg::MODE_FIXED));
    repeat (3) send_tick(tick_of(1'b1, 'h8000, 'h1000, 'hA_0000, 'h6000, 'h6000,
                                 cmh_pkg::MODE_FIXED));
    repeat (3) send_tick(tick_of(1'b1, 'h8000, 'h1000, 'hA_0000, 'h6000, 'h6000,
                                 cmh_pkg::MODE_ROLLING));
    repeat (2) send_tick(tick_of(1'b1, 'h8000, 'h1000, 'hA_0000, 'h6000, 'h6000,
                                 cmh_pkg::MODE_SLIDING));
    send_tick(tick_of(1'b1, 'h7FFF_FFFF, 'h1000, 'hA_0000, 'h6000, 'h6000,
                      cmh_pkg::MODE_FIXED));
    send_tick(tick_of(1'b1, 'h8000, 'h1000, 'hA_0000, 'h6000, 'h6000, cmh_pkg::MODE_FIXED));
    send_tick(tick_of(1'b1, 0, 'h8000_0000, 'hA_0000, 'h6000, 'h6000,
                      cmh_pkg::MODE_ROLLING));
    send_tick(tick_of(1'b1, 0, 'h7FFF_FFFF, 'hA_0000, 'h6000, 'h6000,
                      cmh_pkg::MODE_ROLLING));
    send_tick(tick_of(1'b1, 0, 'h1000, 'h8000_0000, 'h6000, 'h6000, cmh_pkg::MODE_FIXED));
    send_tick(tick_of(1'b1, 'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF,
                      'h7FFF_FFFF, cmh_pkg::MODE_DETACHED));
    send_tick(tick_of(1'b0, 0, 0, 'hA_0000, 'h6000, 'h6000, cmh_pkg::MODE_DETACHED));
    repeat (2) send_tick(tick_of(1'b1, 0, 'h1000, 'hA_0000, 'h6000, 'h6000,
                                 cmh_pkg::MODE_FIXED));
    send_tick(tick_of(1'b1, 0, 0, 'hA_0000, 'h8000_0000, 'h8000_0000,
                      cmh_pkg::MODE_ROLLING));
    send_tick(tick_of(1'b1, 0, 0, 'hA_0000, 'h6000, 'h6000, cmh_pkg::MODE_SLIDING));
    send_tick(tick_of(1'b0, 'h7FFF_FFFF, 0, 'hA_0000, 'h6000, 'h6000,
                      cmh_pkg::MODE_ROLLING));
    settle_all();

    for (int p = 0; p < PHASES; p++) begin
      sc_slip  = $urandom_range(32'h8000, 32'h4_0000);
      sc_res   = $urandom_range(32'h2000, 32'h1_0000);
      sc_force = $urandom_range(32'h4_0000, 32'hA_0000);
      sc_fric  = $urandom_range(32'h1000, 32'h8000);
      sc_torq  = $urandom_range(32'h1000, 32'h8000);
      fill_limits();
      img[cmh_pkg::CFG_DWELL]    = $urandom_range(0, 6);
      img[cmh_pkg::CFG_GAIN]     = $urandom_range(1, 65536);
      img[cmh_pkg::CFG_ACT_STEP] = $urandom_range(1, 65536);
      case (p)
        0: begin
          img[cmh_pkg::CFG_DWELL]    = 0;
          img[cmh_pkg::CFG_GAIN]     = cmh_pkg::Q_ONE;
          img[cmh_pkg::CFG_ACT_STEP] = cmh_pkg::Q_ONE;
        end
        1: begin
          img[cmh_pkg::CFG_DWELL]    = {TW{1'b1}};
          img[cmh_pkg::CFG_GAIN]     = 0;
          img[cmh_pkg::CFG_ACT_STEP] = 0;
        end
        2: begin
          img[cmh_pkg::CFG_DWELL]    = 1;
          img[cmh_pkg::CFG_GAIN]     = {AW{1'b1}};
          img[cmh_pkg::CFG_ACT_STEP] = {AW{1'b1}};
        end
        3: begin
          for (int k = 0; k <= int'(cmh_pkg::CFG_TORQ); k++) img[k] = {$urandom, $urandom};
        end
        4: begin
          img[cmh_pkg::CFG_SLIP]  = {32'h7FFF_FFFF, 32'h8000_0000};
          img[cmh_pkg::CFG_RESID] = {32'h8000_0000, 32'h7FFF_FFFF};
          img[cmh_pkg::CFG_FORCE] = {32'h8000_0000, 32'h8000_0000};
          img[cmh_pkg::CFG_FRIC]  = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
          img[cmh_pkg::CFG_TORQ]  = {64{1'b1}};
        end
        default: ;
      endcase
      program_regs();
      if (p == 5) begin
        burst   = 1'b1;
        squeeze = 1'b1;
      end
      repeat (PHASE_LEN) send_tick(shaped_tick());
      burst = 1'b0;
      settle_all();
    end

    if (board.pending_estimates.size() != 0) begin
      $error("%0d ticks never produced a result", board.pending_estimates.size());
      board.mismatches++;
    end
    $display("summary: %0d ticks checked across %0d register settings",
             board.checked, settings);
    $display("summary: %0d rejected observations, %0d mode commits, one long output stall",
             board.rejects, board.commits);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cmh_pkg.sv
rtl/cmh_if.sv
rtl/cmh_cfg.sv
rtl/cmh_core.sv
rtl/contact_mode_hysteresis_fsm_unit.sv
dv/contact_mode_hysteresis_fsm_unit_tb.sv
